// ===== rtl/gstl_pkg.sv =====
// shared types, codes and helpers for the glyph scan and text layout block
`default_nettype none

package gstl_pkg;

   localparam int COORD_W  = 12;
   localparam int FONTH_W  = 8;
   localparam int STRIP_W  = 13;
   localparam int GWIDTH_W = 8;
   localparam int TOTAL_W  = 7;
   localparam int STATUS_W = 4;
   localparam int CSR_IDX_W = 3;
   localparam int MAX_SCAN = 4096;

   localparam logic [FONTH_W-1:0] FONT_H_RESET = 8'd16;

   localparam logic [7:0] CH_FIRST = 8'h21;
   localparam logic [7:0] CH_LAST  = 8'h7E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [CSR_IDX_W-1:0] REG_BOX_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_W   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_H   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FONT_H  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STRIP_W = 3'd5;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_SCAN  = 2'd2,
      CMD_PUT   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_ACCEPTED   = 4'd0,
      RS_PLACED     = 4'd1,
      RS_SPACE      = 4'd2,
      RS_LINE_BREAK = 4'd3,
      RS_IGNORED    = 4'd4,
      RS_NO_ROOM    = 4'd5,
      RS_NO_FONT    = 4'd6,
      RS_SCANNED    = 4'd7,
      RS_OVERFLOW   = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_BYTE,
      ST_SCAN_RD,
      ST_SCAN_BIT,
      ST_SCAN_END,
      ST_PUT,
      ST_CLR_DONE
   } state_type;

   typedef struct packed {
      logic take;
      logic sweep_init;
      logic sweep_step;
      logic byte_rd;
      logic put_rd;
      logic scan_init;
      logic scan_rd;
      logic scan_bit;
      logic clr_done;
      logic byte_done;
      logic scan_done;
      logic put_done;
   } ctl_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic at_limit;
      logic bit_last;
      logic out_free;
   } ctl_stat_type;

   // (height+2)/3 as a multiply by 171/512, exact for values below 512
   function automatic logic [6:0] space_adv(input logic [FONTH_W-1:0] fh);
      logic [8:0]  v;
      logic [16:0] p;
      v = {1'b0, fh} + 9'd2;
      p = 17'(v) * 17'd171;
      return p[15:9];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gstl_ctrl.sv =====
// sequencer for clear sweeps, font byte updates, strip scans and character placement
`default_nettype none

module gstl_ctrl import gstl_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic [1:0]   req_cmd,
   output logic              req_stall,
   input  wire ctl_stat_type stat,
   output ctl_cmd_type       ctl
);

   state_type state_ff, state_in;
   logic      from_cmd_ff, from_cmd_in;
   logic      accept;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_SWEEP;
         from_cmd_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         from_cmd_ff <= from_cmd_in;
      end
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      from_cmd_in = from_cmd_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (stat.sweep_last) begin
               state_in = from_cmd_ff ? ST_CLR_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_cmd))
                  CMD_CLEAR: begin
                     state_in    = ST_SWEEP;
                     from_cmd_in = 1'b1;
                  end
                  CMD_BYTE: state_in = ST_BYTE;
                  CMD_SCAN: state_in = ST_SCAN_RD;
                  CMD_PUT:  state_in = ST_PUT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN_RD: begin
            state_in = stat.at_limit ? ST_SCAN_END : ST_SCAN_BIT;
         end
         ST_SCAN_BIT: begin
            if (stat.bit_last) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_BYTE, ST_SCAN_END, ST_PUT, ST_CLR_DONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_SWEEP: ctl.sweep_step = 1'b1;
         ST_IDLE: begin
            if (accept) begin
               ctl.take = 1'b1;
               case (cmd_type'(req_cmd))
                  CMD_CLEAR: ctl.sweep_init = 1'b1;
                  CMD_BYTE:  ctl.byte_rd    = 1'b1;
                  CMD_SCAN:  ctl.scan_init  = 1'b1;
                  CMD_PUT:   ctl.put_rd     = 1'b1;
                  default:   ctl.take       = 1'b1;
               endcase
            end
         end
         ST_SCAN_RD:  ctl.scan_rd  = !stat.at_limit;
         ST_SCAN_BIT: ctl.scan_bit = 1'b1;
         ST_BYTE:     ctl.byte_done = stat.out_free;
         ST_SCAN_END: ctl.scan_done = stat.out_free;
         ST_PUT:      ctl.put_done  = stat.out_free;
         ST_CLR_DONE: ctl.clr_done  = stat.out_free;
         default:     ctl = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/gstl_dp.sv =====
// datapath: settings, column store, glyph tables, run tracking, cursor and result register
`default_nettype none

module gstl_dp import gstl_pkg::*; #(
   parameter int ROW_BYTES   = 512,
   parameter int GLYPH_SLOTS = 94
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [STRIP_W-1:0]   csr_wdata,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic [8:0]           req_byte_index,
   input  wire logic [7:0]           req_char_code,
   input  wire ctl_cmd_type          ctl,
   output ctl_stat_type              stat,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COORD_W-1:0]        rsp_draw_x,
   output logic [COORD_W-1:0]        rsp_draw_y,
   output logic [COORD_W-1:0]        rsp_glyph_x,
   output logic [GWIDTH_W-1:0]       rsp_glyph_width,
   output logic [TOTAL_W-1:0]        rsp_glyph_total
);

   localparam int ROW_AW   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int GA_W     = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
   localparam int CNT_W    = $clog2(GLYPH_SLOTS + 1);
   localparam int MAX_COLS = (ROW_BYTES * 8 < MAX_SCAN) ? ROW_BYTES * 8 : MAX_SCAN;

   // settings
   logic [COORD_W-1:0] box_x_ff, box_y_ff, box_w_ff, box_h_ff;
   logic [FONTH_W-1:0] font_h_ff;
   logic [STRIP_W-1:0] strip_w_ff;

   // memories
   logic [7:0]          col_mem [ROW_BYTES];
   logic [7:0]          col_rd_ff;
   logic [COORD_W-1:0]  start_mem [GLYPH_SLOTS];
   logic [GWIDTH_W-1:0] width_mem [GLYPH_SLOTS];
   logic [COORD_W-1:0]  start_rd_ff;
   logic [GWIDTH_W-1:0] width_rd_ff;

   // control state
   logic [ROW_AW-1:0]  sweep_ff, sweep_in;
   logic [STRIP_W-1:0] x_ff, x_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ready_ff, ready_in;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [7:0]          data_ff, data_in;
   logic [ROW_AW-1:0]   idx_ff, idx_in;
   logic                in_range_ff, in_range_in;
   logic [7:0]          char_ff, char_in;
   logic [STRIP_W-1:0]  limit_ff, limit_in;
   logic [COORD_W-1:0]  run_start_ff, run_start_in;
   logic                prev_ff, prev_in;
   logic                ovf_ff, ovf_in;
   status_type          status_ff, status_in;
   logic [COORD_W-1:0]  dx_ff, dx_in, dy_ff, dy_in, gx_ff, gx_in;
   logic [GWIDTH_W-1:0] gw_ff, gw_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;

   // memory ports
   logic              col_we, col_re;
   logic [ROW_AW-1:0] col_waddr, col_raddr;
   logic [7:0]        col_wdata;
   logic              tbl_we;
   logic [GA_W-1:0]   tbl_raddr;

   // scan
   logic               px;
   logic               close_now;
   logic               tbl_room;
   logic [STRIP_W-1:0] run_w;
   logic [GWIDTH_W-1:0] run_w_sat;

   // placement
   logic [STRIP_W-1:0]       end_x, end_y;
   logic signed [14:0]       room_x, room_y;
   logic [8:0]               fh_p1, gw_p1;
   logic                     brk_ok, glyph_need, sp_need, is_glyph;
   logic [7:0]               slot;
   logic [6:0]               sw;
   logic [COORD_W-1:0]       brk_y, base_x, base_y;
   status_type               res_status;
   logic [COORD_W-1:0]       res_dx, res_dy, res_gx;
   logic [GWIDTH_W-1:0]      res_gw;
   logic                     done;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff   <= '0;
         box_y_ff   <= '0;
         box_w_ff   <= '0;
         box_h_ff   <= '0;
         font_h_ff  <= FONT_H_RESET;
         strip_w_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_BOX_X:   box_x_ff   <= csr_wdata[COORD_W-1:0];
            REG_BOX_Y:   box_y_ff   <= csr_wdata[COORD_W-1:0];
            REG_BOX_W:   box_w_ff   <= csr_wdata[COORD_W-1:0];
            REG_BOX_H:   box_h_ff   <= csr_wdata[COORD_W-1:0];
            REG_FONT_H:  font_h_ff  <= csr_wdata[FONTH_W-1:0];
            REG_STRIP_W: strip_w_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // column store: zero sweep or read-modify-write of one font byte
   assign col_we    = ctl.sweep_step || (ctl.byte_done && in_range_ff);
   assign col_waddr = ctl.sweep_step ? sweep_ff : idx_ff;
   assign col_wdata = ctl.sweep_step ? 8'h00 : (col_rd_ff | ~data_ff);
   assign col_re    = ctl.byte_rd || ctl.scan_rd;
   assign col_raddr = ctl.byte_rd ? ROW_AW'(req_byte_index) : ROW_AW'(x_ff >> 3);

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_waddr] <= col_wdata;
      end
      if (col_re) begin
         col_rd_ff <= col_mem[col_raddr];
      end
   end

   // glyph tables, written in slot order while scanning
   assign tbl_raddr = GA_W'(req_char_code - CH_FIRST);

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         start_mem[GA_W'(count_ff)] <= run_start_ff;
         width_mem[GA_W'(count_ff)] <= run_w_sat;
      end
      if (ctl.put_rd) begin
         start_rd_ff <= start_mem[tbl_raddr];
         width_rd_ff <= width_mem[tbl_raddr];
      end
   end

   // run tracking; msb of a byte is the leftmost column
   assign px        = col_rd_ff[~x_ff[2:0]];
   assign close_now = prev_ff && ((ctl.scan_bit && !px) || ctl.scan_done);
   assign tbl_room  = (count_ff < CNT_W'(GLYPH_SLOTS));
   assign tbl_we    = close_now && tbl_room;
   assign run_w     = x_ff - {1'b0, run_start_ff};
   assign run_w_sat = (run_w > 13'd255) ? 8'hFF : run_w[GWIDTH_W-1:0];

   assign stat.sweep_last = (sweep_ff == ROW_AW'(ROW_BYTES - 1));
   assign stat.at_limit   = (x_ff == limit_ff);
   assign stat.bit_last   = (&x_ff[2:0]) || (x_ff + 13'd1 == limit_ff);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   // room left in the box, signed so a cursor past the edge goes negative
   assign end_x  = {1'b0, box_x_ff} + {1'b0, box_w_ff};
   assign end_y  = {1'b0, box_y_ff} + {1'b0, box_h_ff};
   assign room_x = $signed({2'b00, end_x}) - $signed({3'b000, cur_x_ff});
   assign room_y = $signed({2'b00, end_y}) - $signed({3'b000, cur_y_ff});
   assign fh_p1  = {1'b0, font_h_ff} + 9'd1;
   assign brk_ok = !($signed({6'b0, fh_p1}) > room_y);
   assign brk_y  = cur_y_ff + {4'b0, font_h_ff} + 12'd1;

   assign slot       = char_ff - CH_FIRST;
   assign gw_p1      = {1'b0, width_rd_ff} + 9'd1;
   assign glyph_need = $signed({6'b0, gw_p1}) > room_x;
   assign sw         = space_adv(font_h_ff);
   assign sp_need    = $signed({8'b0, sw}) > room_x;
   assign is_glyph   = (char_ff >= CH_FIRST) && (char_ff <= CH_LAST) &&
                       ({1'b0, slot} < 9'(count_ff)) && (width_rd_ff != 8'd0);
   assign base_x     = glyph_need ? box_x_ff : cur_x_ff;
   assign base_y     = glyph_need ? brk_y : cur_y_ff;

   assign done = ctl.clr_done || ctl.byte_done || ctl.scan_done || ctl.put_done;

   always_comb begin
      sweep_in     = sweep_ff;
      x_in         = x_ff;
      count_in     = count_ff;
      ready_in     = ready_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      data_in      = data_ff;
      idx_in       = idx_ff;
      in_range_in  = in_range_ff;
      char_in      = char_ff;
      limit_in     = limit_ff;
      run_start_in = run_start_ff;
      prev_in      = prev_ff;
      ovf_in       = ovf_ff;
      res_status   = RS_ACCEPTED;
      res_dx       = '0;
      res_dy       = '0;
      res_gx       = '0;
      res_gw       = '0;

      if (ctl.take) begin
         data_in     = req_data_byte;
         idx_in      = ROW_AW'(req_byte_index);
         in_range_in = (32'(req_byte_index) < ROW_BYTES);
         char_in     = req_char_code;
      end
      if (ctl.sweep_init) begin
         sweep_in = '0;
      end
      if (ctl.sweep_step) begin
         sweep_in = sweep_ff + ROW_AW'(1);
      end

      if (ctl.scan_init) begin
         x_in     = '0;
         prev_in  = 1'b0;
         ovf_in   = 1'b0;
         count_in = '0;
         limit_in = (strip_w_ff > STRIP_W'(MAX_COLS)) ? STRIP_W'(MAX_COLS) : strip_w_ff;
      end
      if (ctl.scan_bit) begin
         if (px && !prev_ff) begin
            run_start_in = x_ff[COORD_W-1:0];
         end
         prev_in = px;
         x_in    = x_ff + 13'd1;
      end
      if (close_now) begin
         if (tbl_room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (ctl.scan_done) begin
         ready_in   = 1'b1;
         res_status = (ovf_ff || (close_now && !tbl_room)) ? RS_OVERFLOW : RS_SCANNED;
      end

      if (ctl.clr_done) begin
         count_in   = '0;
         ready_in   = 1'b0;
         cur_x_in   = box_x_ff;
         cur_y_in   = box_y_ff;
         res_status = RS_ACCEPTED;
      end

      if (ctl.byte_done) begin
         res_status = in_range_ff ? RS_ACCEPTED : RS_IGNORED;
      end

      if (ctl.put_done) begin
         if (!ready_ff) begin
            res_status = RS_NO_FONT;
         end else if (is_glyph) begin
            if (glyph_need && !brk_ok) begin
               res_status = RS_NO_ROOM;
            end else begin
               res_status = RS_PLACED;
               res_dx     = base_x;
               res_dy     = base_y;
               res_gx     = start_rd_ff;
               res_gw     = width_rd_ff;
               cur_x_in   = base_x + {4'b0, width_rd_ff} + 12'd1;
               cur_y_in   = base_y;
            end
         end else if (char_ff == CH_SPACE) begin
            if (!sp_need) begin
               cur_x_in   = cur_x_ff + {5'b0, sw};
               res_status = RS_SPACE;
            end else if (brk_ok) begin
               cur_x_in   = box_x_ff;
               cur_y_in   = brk_y;
               res_status = RS_SPACE;
            end else begin
               res_status = RS_NO_ROOM;
            end
         end else if ((char_ff == CH_CR) || (char_ff == CH_LF)) begin
            if (brk_ok) begin
               cur_x_in   = box_x_ff;
               cur_y_in   = brk_y;
               res_status = RS_LINE_BREAK;
            end else begin
               res_status = RS_NO_ROOM;
            end
         end else begin
            res_status = RS_IGNORED;
         end
      end
   end

   // result register, loaded only when the previous result has gone
   always_comb begin
      rsp_valid_in = done ? 1'b1 : (rsp_valid_ff && rsp_stall);
      status_in    = status_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      gx_in        = gx_ff;
      gw_in        = gw_ff;
      total_in     = total_ff;
      if (done) begin
         status_in = res_status;
         dx_in     = res_dx;
         dy_in     = res_dy;
         gx_in     = res_gx;
         gw_in     = res_gw;
         total_in  = TOTAL_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         x_ff         <= '0;
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         x_ff         <= x_in;
         count_ff     <= count_in;
         ready_ff     <= ready_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff      <= data_in;
      idx_ff       <= idx_in;
      in_range_ff  <= in_range_in;
      char_ff      <= char_in;
      limit_ff     <= limit_in;
      run_start_ff <= run_start_in;
      prev_ff      <= prev_in;
      ovf_ff       <= ovf_in;
      status_ff    <= status_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      gx_ff        <= gx_in;
      gw_ff        <= gw_in;
      total_ff     <= total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_draw_x      = dx_ff;
   assign rsp_draw_y      = dy_ff;
   assign rsp_glyph_x     = gx_ff;
   assign rsp_glyph_width = gw_ff;
   assign rsp_glyph_total = total_ff;

endmodule

`default_nettype wire

// ===== rtl/glyph_scan_text_layout.sv =====
// glyph_scan_text_layout: font strip scanner and text cursor layout engine
// Requests come in on req_* (valid/stall) and each one gives exactly one result on
// rsp_* (valid/stall). Settings go through csr_* (valid/ready, always ready); the user
// must write them only while no request is in flight: the block does not enforce it.
// Steps from a request transfer to its result in the output register; the next
// request is taken in the cycle after that:
//   font byte: registered read of the column store, then the OR write
//   put character: registered read of the glyph tables, then the cursor update
//   clear: the column store is zeroed one byte a cycle
//   scan: each byte is read out of the column store, then its columns are
//   walked one column a cycle
// Requests are handled one at a time; req_stall is high while one is in progress.
// After reset the block runs a clearing pass over the column store with req_stall
// high; settings writes are taken during it.
// The result sits in an output register. While rsp_stall holds it, the next request
// is still taken and worked on, and its result waits until the register frees.
`default_nettype none

module glyph_scan_text_layout import gstl_pkg::*; #(
   parameter int ROW_BYTES   = 512,
   parameter int GLYPH_SLOTS = 94
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic [8:0]           req_byte_index,
   input  wire logic [7:0]           req_char_code,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COORD_W-1:0]        rsp_draw_x,
   output logic [COORD_W-1:0]        rsp_draw_y,
   output logic [COORD_W-1:0]        rsp_glyph_x,
   output logic [GWIDTH_W-1:0]       rsp_glyph_width,
   output logic [TOTAL_W-1:0]        rsp_glyph_total,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [STRIP_W-1:0]   csr_wdata
);

   ctl_cmd_type  ctl;
   ctl_stat_type stat;
   logic         ctl_done;

   gstl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   gstl_dp #(
      .ROW_BYTES   (ROW_BYTES),
      .GLYPH_SLOTS (GLYPH_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_data_byte   (req_data_byte),
      .req_byte_index  (req_byte_index),
      .req_char_code   (req_char_code),
      .ctl             (ctl),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_draw_x      (rsp_draw_x),
      .rsp_draw_y      (rsp_draw_y),
      .rsp_glyph_x     (rsp_glyph_x),
      .rsp_glyph_width (rsp_glyph_width),
      .rsp_glyph_total (rsp_glyph_total)
   );

   assign ctl_done = ctl.clr_done || ctl.byte_done || ctl.scan_done || ctl.put_done;

   // the clearing pass holds off requests right after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("request not held off during the clearing pass");

   // a result is only loaded into a free output register
   a_done_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl_done |-> stat.out_free)
      else $error("result loaded over one not yet taken");

   // no request transfer while a result is being produced
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !ctl_done)
      else $error("request taken while another finishes");

   // a placed glyph always has a width
   a_placed_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == RS_PLACED)) |-> (rsp_glyph_width != 8'd0))
      else $error("placed glyph with zero width");

endmodule

`default_nettype wire
